// ----- sv/tkrs_pkg.sv -----
// tkrs_pkg: shared types and constants for the threshold top-k region selector
// used by tkrs_front, tkrs_back and threshold_top_k_region_select
// no dependencies
`default_nettype none

package tkrs_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned TOP_MAX_W = 5;
    localparam int unsigned CFG_IDX_W = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_MAX   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COV_LEVEL = 8'd1;

    localparam logic [TOP_MAX_W-1:0] TOP_MAX_RESET = 5'd16;

    // queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    // classified item as it travels from front to back
    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic [DATA_W-1:0] coverage;
        logic              qual;
        logic              fin;
    } t_item;

    typedef enum logic {
        ST_INSERT,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/threshold_top_k_region_select.sv -----
// threshold_top_k_region_select: top level, config registers, front and back
// depends on tkrs_pkg, tkrs_front, tkrs_back
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      region start, length, coverage, final
// out       output     o_out_valid / i_out_stall    start, length, coverage, found, last
// cfg       input      i_cfg_valid / o_cfg_ready    register index, write data
//
// each region is inserted into the back table as it is popped; the queue lets the front keep
// taking transfers while the back is busy
// a final region holds the back while it emits one result per kept entry (a single one when
// none qualified), paced by the single output register
// synchronous active-low reset empties the queue and table count, top_max resets to 16
// output stall holds the result register; input stall rises only when the queue is full
`default_nettype none

module threshold_top_k_region_select
    import tkrs_pkg::*;
#(
    parameter int unsigned MAX_TOP = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input region stream
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [DATA_W-1:0]    i_region_start,
    input  wire logic [DATA_W-1:0]    i_region_length,
    input  wire logic [DATA_W-1:0]    i_region_coverage,
    input  wire logic                 i_final_item,
    // selected region stream
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [DATA_W-1:0]         o_out_start,
    output logic [DATA_W-1:0]         o_out_length,
    output logic [DATA_W-1:0]         o_out_coverage,
    output logic                      o_found,
    output logic                      o_last_result,
    // config writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    logic [TOP_MAX_W-1:0] r_top_max;
    logic [DATA_W-1:0]    r_cov_level;
    logic                 q_valid;
    t_item                q_item;
    logic                 q_pop;

    // config is always taken; writes beyond the register list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_max   <= TOP_MAX_RESET;
            r_cov_level <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOP_MAX:   r_top_max   <= i_cfg_data[TOP_MAX_W-1:0];
                CFG_COV_LEVEL: r_cov_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: takes transfers, applies the coverage threshold, queues items
    tkrs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_region_start    (i_region_start),
        .i_region_length   (i_region_length),
        .i_region_coverage (i_region_coverage),
        .i_final_item      (i_final_item),
        .i_cov_level       (r_cov_level),
        .o_q_valid         (q_valid),
        .o_q_item          (q_item),
        .i_pop             (q_pop)
    );

    // back: sorted table insert and ordered drain on the final region
    tkrs_back #(
        .MAX_TOP (MAX_TOP)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (q_pop),
        .i_top_max      (r_top_max),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_start    (o_out_start),
        .o_out_length   (o_out_length),
        .o_out_coverage (o_out_coverage),
        .o_found        (o_found),
        .o_last_result  (o_last_result)
    );

endmodule

`default_nettype wire

// ----- sv/tkrs_front.sv -----
// tkrs_front: input acceptance, threshold classification and a short item queue
// depends on tkrs_pkg
`default_nettype none

module tkrs_front
    import tkrs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [DATA_W-1:0] i_region_start,
    input  wire logic [DATA_W-1:0] i_region_length,
    input  wire logic [DATA_W-1:0] i_region_coverage,
    input  wire logic              i_final_item,
    input  wire logic [DATA_W-1:0] i_cov_level,
    output logic                   o_q_valid,
    output t_item                  o_q_item,
    input  wire logic              i_pop
);

    t_item               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic [Q_CNT_W-1:0]  n_cnt;
    logic                push;
    t_item               item_in;

    assign o_in_stall = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_q[r_rd_ptr];

    // classify on the way in
    always_comb begin
        item_in.start    = i_region_start;
        item_in.length   = i_region_length;
        item_in.coverage = i_region_coverage;
        item_in.qual     = (i_region_coverage >= i_cov_level);
        item_in.fin      = i_final_item;
    end

    always_comb begin
        case ({push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item_in;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");

    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !push) |=> !o_q_valid)
        else $error("queue shows data without a transfer");
`endif

endmodule

`default_nettype wire

// ----- sv/tkrs_back.sv -----
// tkrs_back: sorted top-k table with insertion of each popped item and head shift-out
// depends on tkrs_pkg
`default_nettype none

module tkrs_back
    import tkrs_pkg::*;
#(
    parameter int unsigned MAX_TOP = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire t_item                i_q_item,
    output logic                      o_pop,
    input  wire logic [TOP_MAX_W-1:0] i_top_max,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [DATA_W-1:0]         o_out_start,
    output logic [DATA_W-1:0]         o_out_length,
    output logic [DATA_W-1:0]         o_out_coverage,
    output logic                      o_found,
    output logic                      o_last_result
);

    localparam int unsigned CW = $clog2(MAX_TOP + 1);
    localparam int unsigned LW = (CW > TOP_MAX_W) ? CW : TOP_MAX_W;

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [DATA_W-1:0]   r_start [MAX_TOP];
    logic [DATA_W-1:0]   r_len   [MAX_TOP];
    logic [DATA_W-1:0]   r_cov   [MAX_TOP];
    logic [DATA_W-1:0]   n_start [MAX_TOP];
    logic [DATA_W-1:0]   n_len   [MAX_TOP];
    logic [DATA_W-1:0]   n_cov   [MAX_TOP];

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_start;
    logic [DATA_W-1:0]   r_out_length;
    logic [DATA_W-1:0]   r_out_coverage;
    logic                r_found;
    logic                r_last;

    logic [LW-1:0]       tm_ext;
    logic [LW-1:0]       lim_w;
    logic [CW-1:0]       lim;
    logic [CW-1:0]       c_eff;
    logic [CW-1:0]       ins_count;
    logic [MAX_TOP-1:0]  vld;
    logic [MAX_TOP-1:0]  ge;
    logic                all_ge;
    logic                pop;
    logic                do_ins;
    logic                out_free;
    logic                do_emit;

    // effective limit, clamped to 1..MAX_TOP
    always_comb begin
        tm_ext = LW'(i_top_max);
        if (tm_ext == '0) begin
            lim_w = LW'(1);
        end else if (tm_ext > LW'(MAX_TOP)) begin
            lim_w = LW'(MAX_TOP);
        end else begin
            lim_w = tm_ext;
        end
        lim   = lim_w[CW-1:0];
        c_eff = (r_count > lim) ? lim : r_count;
    end

    // per-entry compare against the incoming coverage
    always_comb begin
        for (int i = 0; i < MAX_TOP; i++) begin
            vld[i] = (CW'(i) < c_eff);
            ge[i]  = vld[i] && (r_cov[i] >= i_q_item.coverage);
        end
        all_ge = &(ge | ~vld);
    end

    // fsm outputs
    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        pop      = (r_state == ST_INSERT) && i_q_valid;
        do_emit  = (r_state == ST_EMIT) && out_free;
    end

    assign o_pop = pop;

    always_comb begin
        do_ins    = pop && i_q_item.qual && !((c_eff == lim) && all_ge);
        ins_count = (do_ins && (c_eff < lim)) ? (c_eff + 1'b1) : c_eff;
    end

    // fsm next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INSERT: begin
                if (pop && i_q_item.fin) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (do_emit && (r_count <= CW'(1))) begin
                    n_state = ST_INSERT;
                end
            end
            default: n_state = ST_INSERT;
        endcase
    end

    // table update: insert at first lower entry, or shift out the head
    always_comb begin
        n_count = r_count;
        n_start = r_start;
        n_len   = r_len;
        n_cov   = r_cov;
        if (pop) begin
            n_count = ins_count;
        end
        if (do_ins) begin
            for (int i = 0; i < MAX_TOP; i++) begin
                if (!ge[i]) begin
                    if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                        n_start[i] = i_q_item.start;
                        n_len[i]   = i_q_item.length;
                        n_cov[i]   = i_q_item.coverage;
                    end else begin
                        n_start[i] = r_start[(i == 0) ? 0 : i - 1];
                        n_len[i]   = r_len[(i == 0) ? 0 : i - 1];
                        n_cov[i]   = r_cov[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
        if (do_emit && (r_count != '0)) begin
            n_count = r_count - 1'b1;
            for (int i = 0; i < MAX_TOP - 1; i++) begin
                n_start[i] = r_start[i + 1];
                n_len[i]   = r_len[i + 1];
                n_cov[i]   = r_cov[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INSERT;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_len   <= n_len;
        r_cov   <= n_cov;
        if (do_emit) begin
            r_out_start    <= (r_count != '0) ? r_start[0] : '0;
            r_out_length   <= (r_count != '0) ? r_len[0]   : '0;
            r_out_coverage <= (r_count != '0) ? r_cov[0]   : '0;
            r_found        <= (r_count != '0);
            r_last         <= (r_count <= CW'(1));
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_start    = r_out_start;
    assign o_out_length   = r_out_length;
    assign o_out_coverage = r_out_coverage;
    assign o_found        = r_found;
    assign o_last_result  = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TOP))
        else $error("kept count above table size");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_emit && (r_count <= CW'(1))) |=> (r_state == ST_INSERT))
        else $error("emit did not end after last entry");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> o_last_result)
        else $error("empty result not marked last");
`endif

endmodule

`default_nettype wire
